@@ hw/rtl/marker_frame_extractor_unit_macros.svh @@
// Assertion helpers used by marker_frame_extractor_unit.sv.
`ifndef MARKER_FRAME_EXTRACTOR_UNIT_MACROS_SVH
`define MARKER_FRAME_EXTRACTOR_UNIT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define MFE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MFE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define MFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mfe_pkg.sv @@
package mfe_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'hFF;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

endpackage

@@ hw/rtl/mfe_rx_if.sv @@
interface mfe_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

@@ hw/rtl/mfe_frame_if.sv @@
interface mfe_frame_if;

    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       frame_empty;

    modport source (output valid, output frame_byte, output frame_last, output frame_empty,
                    input ready);
    modport sink   (input valid, input frame_byte, input frame_last, input frame_empty,
                    output ready);

endinterface

@@ hw/rtl/marker_frame_extractor_unit.sv @@
// Start/end marker deframer.
// Channel rx carries one received byte per item. Channel frame carries the
// payload of a completed frame, one byte per item, frame_last on the final
// one; a frame with no payload gives a single item with frame_empty set.
// AA AA (re)starts capture, FF FF ends the frame while capturing.
// Flow: a byte that does not end a frame leaves rx ready for the next
// byte. An end marker holds rx off while the frame is replayed from the
// frame store: entry zero is read at the edge that takes the marker, so
// the first frame item is valid in the next cycle, then one item per
// cycle while frame is ready, until the last item is taken. The single
// read port of the store sets the rate of one item per cycle.
// Reset: capture is on, the previous byte reads as zero, the write index is
// zero. The store itself is not cleared; only written entries are replayed.
// Stall: while frame is not ready the current item holds and the store
// read address stays put; rx stays not ready until the last item is taken.

`include "marker_frame_extractor_unit_macros.svh"

module marker_frame_extractor_unit (
    input  logic         clk,
    input  logic         rst_n,
    mfe_rx_if.sink       rx,
    mfe_frame_if.source  frame
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMPTY
    } state_t;

    state_t          state_reg;
    logic [7:0]      prev_reg;
    logic            capturing_reg;
    mfe_pkg::count_t write_index_reg;
    logic            last_ff_reg;
    mfe_pkg::addr_t  idx_reg;
    mfe_pkg::addr_t  last_idx_reg;

    // Frame store: one write port, one registered read port.
    logic [7:0]      store_mem [mfe_pkg::BUFFER_DEPTH];
    logic [7:0]      store_q;

    logic            in_accept;
    logic            out_accept;
    logic            start_pair;
    logic            end_pair;
    logic            wr_en;
    logic            room;
    mfe_pkg::count_t frame_len;
    mfe_pkg::addr_t  rd_addr;
    logic            drain_last;

    assign in_accept  = rx.valid && rx.ready;
    assign out_accept = frame.valid && frame.ready;

    assign start_pair = (prev_reg == mfe_pkg::START_BYTE) && (rx.rx_byte == mfe_pkg::START_BYTE);
    assign end_pair   = (prev_reg == mfe_pkg::END_BYTE) && (rx.rx_byte == mfe_pkg::END_BYTE)
                        && capturing_reg;
    assign room       = write_index_reg < mfe_pkg::CNT_W'(mfe_pkg::BUFFER_DEPTH);
    assign wr_en      = in_accept && !start_pair && !end_pair && capturing_reg && room;

    // Drop the trailing FF of the end marker, which was already stored.
    always_comb
    begin
        if ((write_index_reg != '0) && last_ff_reg)
        begin
            frame_len = write_index_reg - mfe_pkg::CNT_W'(1);
        end
        else
        begin
            frame_len = write_index_reg;
        end
    end

    assign drain_last = (idx_reg == last_idx_reg);

    // Read address: advance ahead of the output so store_q always holds
    // the entry at idx_reg; start at entry zero while idle.
    always_comb
    begin
        unique case (state_reg)
            ST_DRAIN:
            begin
                if (out_accept)
                begin
                    rd_addr = idx_reg + mfe_pkg::ADDR_W'(1);
                end
                else
                begin
                    rd_addr = idx_reg;
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[write_index_reg[mfe_pkg::ADDR_W-1:0]] <= rx.rx_byte;
        end
        store_q <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_reg        <= '0;
            capturing_reg   <= 1'b1;
            write_index_reg <= '0;
            last_ff_reg     <= 1'b0;
            idx_reg         <= '0;
            last_idx_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        prev_reg <= rx.rx_byte;
                        priority if (start_pair)
                        begin
                            capturing_reg   <= 1'b1;
                            write_index_reg <= '0;
                        end
                        else if (end_pair)
                        begin
                            capturing_reg   <= 1'b0;
                            write_index_reg <= frame_len;
                            idx_reg         <= '0;
                            if (frame_len == '0)
                            begin
                                state_reg <= ST_EMPTY;
                            end
                            else
                            begin
                                last_idx_reg <= mfe_pkg::ADDR_W'(frame_len
                                                                  - mfe_pkg::CNT_W'(1));
                                state_reg    <= ST_DRAIN;
                            end
                        end
                        else if (capturing_reg)
                        begin
                            if (room)
                            begin
                                write_index_reg <= write_index_reg + mfe_pkg::CNT_W'(1);
                                last_ff_reg     <= (rx.rx_byte == mfe_pkg::END_BYTE);
                            end
                            // Stop capture once the store is full.
                            if (!room || (write_index_reg
                                == mfe_pkg::CNT_W'(mfe_pkg::BUFFER_DEPTH - 1)))
                            begin
                                capturing_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            // Not capturing: drop the byte.
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_accept)
                    begin
                        if (drain_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + mfe_pkg::ADDR_W'(1);
                        end
                    end
                end
                ST_EMPTY:
                begin
                    if (out_accept)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rx.ready          = (state_reg == ST_IDLE);
    assign frame.valid       = (state_reg == ST_DRAIN) || (state_reg == ST_EMPTY);
    assign frame.frame_byte  = (state_reg == ST_DRAIN) ? store_q : 8'h00;
    assign frame.frame_last  = (state_reg == ST_EMPTY) || ((state_reg == ST_DRAIN) && drain_last);
    assign frame.frame_empty = (state_reg == ST_EMPTY);

    // Input and output sides never run at once.
    `MFE_ASSERT_IMPLIES(a_no_overlap, rx.ready, !frame.valid, "rx ready while frame valid")
    // Capture on implies room left in the store.
    `MFE_ASSERT_IMPLIES(a_capture_room, capturing_reg, room, "capturing with a full store")
    // Write index never passes the store depth.
    `MFE_ASSERT_ALWAYS(a_index_range,
        write_index_reg <= mfe_pkg::CNT_W'(mfe_pkg::BUFFER_DEPTH), "write index out of range")
    // Taking the last item frees the input side.
    `MFE_ASSERT_NEXT(a_last_frees, out_accept && frame.frame_last, rx.ready,
        "rx not ready after last frame item")

endmodule
